[rtl/core/json_string_unescape_macros.svh]
// ----------------------------------------------------------------------------
// json_string_unescape_macros.svh
// Assertion macros for the string unescape block; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle
`define JSU_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("json_string_unescape: same-cycle check failed");

// Check that a condition implies another in the next cycle
`define JSU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("json_string_unescape: next-cycle check failed");

`else

`define JSU_ASSERT_SAME(label, clk_s, rst_s, ante, cons)
`define JSU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

[rtl/core/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescape block.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_BSL_END = 2'd1;
  localparam status_t STATUS_UNI_TRC = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_U   = 8'h75;

  // Control codes for the short escapes
  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_FF  = 8'h0C;
  localparam logic [7:0] CC_LF  = 8'h0A;
  localparam logic [7:0] CC_CR  = 8'h0D;
  localparam logic [7:0] CC_TAB = 8'h09;

  // One decoded result from the step logic
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    status_t    status;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/jsu_step.sv]
// ----------------------------------------------------------------------------
// jsu_step
// Escape state machine: holds the escape mode and hex accumulator and
// works out the result of the byte offered in this cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_step import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output result_t         res
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_X1     = 3'd2,
    MODE_X2     = 3'd3,
    MODE_U1     = 3'd4,
    MODE_U2     = 3'd5,
    MODE_U3     = 3'd6,
    MODE_U4     = 3'd7
  } mode_t;

  mode_t      mode, mode_next;
  logic [7:0] accum, accum_next;
  logic       stopped, stopped_next;

  logic       is_hex;
  logic [3:0] hex_val;
  logic [7:0] tk_accum;
  logic       tk_stopped;
  logic [7:0] esc_char;

  // Decode one hex digit
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (in_byte inside {[8'h30:8'h39]}) begin
      hex_val = in_byte[3:0];
    end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_val = in_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // Fold the digit into the accumulator unless decoding has stopped
  always_comb begin
    tk_accum   = accum;
    tk_stopped = stopped;
    if (!stopped) begin
      if (is_hex) begin
        tk_accum = {accum[3:0], hex_val};
      end else begin
        tk_stopped = 1'b1;
      end
    end
  end

  // Map the single-letter escapes
  always_comb begin
    case (in_byte)
      CH_B:    esc_char = CC_BS;
      CH_F:    esc_char = CC_FF;
      CH_N:    esc_char = CC_LF;
      CH_R:    esc_char = CC_CR;
      CH_T:    esc_char = CC_TAB;
      default: esc_char = in_byte;
    endcase
  end

  // Next state and result
  always_comb begin
    mode_next    = mode;
    accum_next   = accum;
    stopped_next = stopped;
    res.emit     = 1'b0;
    res.data     = 8'd0;
    res.status   = STATUS_OK;
    res.last     = in_last;

    case (mode)
      MODE_NORMAL: begin
        if (in_byte == CH_BSL) begin
          if (in_last) begin
            res.emit   = 1'b1;
            res.status = STATUS_BSL_END;
          end else begin
            mode_next = MODE_ESC;
          end
        end else begin
          res.emit = 1'b1;
          res.data = in_byte;
        end
      end
      MODE_ESC: begin
        if (in_byte == CH_X || in_byte == CH_U) begin
          accum_next   = 8'd0;
          stopped_next = 1'b0;
          if (in_last) begin
            res.emit   = 1'b1;
            res.status = (in_byte == CH_X) ? STATUS_OK : STATUS_UNI_TRC;
          end else begin
            mode_next = (in_byte == CH_X) ? MODE_X1 : MODE_U1;
          end
        end else begin
          res.emit  = 1'b1;
          res.data  = esc_char;
          mode_next = MODE_NORMAL;
        end
      end
      MODE_X1, MODE_U3: begin
        accum_next   = tk_accum;
        stopped_next = tk_stopped;
        if (in_last) begin
          res.emit = 1'b1;
          res.data = tk_accum;
        end else begin
          mode_next = (mode == MODE_X1) ? MODE_X2 : MODE_U4;
        end
      end
      MODE_X2, MODE_U4: begin
        accum_next   = tk_accum;
        stopped_next = tk_stopped;
        res.emit     = 1'b1;
        res.data     = tk_accum;
        mode_next    = MODE_NORMAL;
      end
      MODE_U1: begin
        if (in_last) begin
          res.emit   = 1'b1;
          res.status = STATUS_UNI_TRC;
        end else begin
          mode_next = MODE_U2;
        end
      end
      MODE_U2: begin
        if (in_last) begin
          res.emit = 1'b1;
        end else begin
          mode_next = MODE_U3;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase

    // End of string: start the next one clean
    if (in_last) begin
      mode_next    = MODE_NORMAL;
      accum_next   = 8'd0;
      stopped_next = 1'b0;
    end
  end

  // Hold state; advance on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NORMAL;
      accum   <= 8'd0;
      stopped <= 1'b0;
    end else if (take) begin
      mode    <= mode_next;
      accum   <= accum_next;
      stopped <= stopped_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/json_string_unescape.sv]
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming decoder for the escapes in the body of a quoted JSON string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one raw byte per transfer with
//   in_last set on the final byte of a string. Output channel (out_valid /
//   out_stall) carries at most one decoded byte per input byte, with a status
//   code and out_last copied from the byte that caused it.
//   A result is registered in the output register and appears there in the cycle
//   after the transfer of the byte that completes it. Throughput: one byte per cycle
//   while out_stall is low, set by the single escape state update per byte.
//   Bytes inside an escape (the backslash, the x or u, hex digits) produce no
//   result until the escape ends; a final byte always produces one.
//   When the receiver stalls, the output register holds its result and
//   in_stall rises, so no further byte is taken until the result is moved.
//   Reset clears the escape state and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_macros.svh"

module json_string_unescape import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output status_t         out_status,
  output logic            out_last
);

  logic    take;
  result_t res;

  // Stall the input only while a result waits and cannot leave
  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  jsu_step u_step (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (res)
  );

  // Output register: load a new result, drop one that has been moved
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && res.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.emit) begin
      out_byte   <= res.data;
      out_status <= res.status;
      out_last   <= res.last;
    end
  end

  // Error results carry a zero byte and always end the string
  `JSU_ASSERT_SAME(a_err_zero, clk, rst, out_valid && out_status != STATUS_OK, out_byte == 8'd0)
  `JSU_ASSERT_SAME(a_err_last, clk, rst, out_valid && out_status != STATUS_OK, out_last)
  // Only the three defined codes leave the block
  `JSU_ASSERT_SAME(a_status_ok, clk, rst, out_valid,
                   out_status == STATUS_OK || out_status == STATUS_BSL_END ||
                   out_status == STATUS_UNI_TRC)
  // A stalled result is not overwritten
  `JSU_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_byte))

endmodule

`default_nettype wire

[sim/tb_json_string_unescape.sv]
// ----------------------------------------------------------------------------
// tb_json_string_unescape
// Self-checking testbench for the JSON string unescape block. A scoreboard
// predicts every decoded byte from the raw bytes accepted on the input, and
// compares each result transfer with the oldest prediction. Stimulus is a
// short directed run over hex, unicode and unknown escapes and ways a string
// can end, then random strings built mostly of well-formed escapes with random
// content. Both sides idle at random, with one long stretch with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

import jsu_pkg::*;

// Escape decoder position, one step per raw byte
typedef enum logic [2:0] {
  ESC_IDLE,
  ESC_OPEN,
  ESC_X_HI,
  ESC_X_LO,
  ESC_U_SKIP1,
  ESC_U_SKIP2,
  ESC_U_HI,
  ESC_U_LO
} esc_mode_t;

typedef struct {
  logic [7:0] data;
  status_t    status;
  logic       last;
} decoded_t;

class unescape_scoreboard;
  decoded_t   decoded_q[$];
  int         errors;
  esc_mode_t  mode;
  logic [7:0] accum;
  logic       stopped;

  function new();
    errors = 0;
    clear_state();
  endfunction

  function void clear_state();
    mode    = ESC_IDLE;
    accum   = 8'h00;
    stopped = 1'b0;
  endfunction

  // Fold one hex digit into the value; stop for good at the first non-hex byte
  function void take_digit(logic [7:0] c);
    logic [3:0] nib;
    logic       ok;
    ok  = 1'b1;
    nib = 4'h0;
    if (c >= "0" && c <= "9") nib = 4'(c - "0");
    else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 10);
    else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
    else ok = 1'b0;
    if (stopped) return;
    if (!ok) begin
      stopped = 1'b1;
      return;
    end
    accum = {accum[3:0], nib};
  endfunction

  function void push(logic [7:0] data, status_t status, logic last);
    decoded_t d;
    d.data   = data;
    d.status = status;
    d.last   = last;
    decoded_q.push_back(d);
  endfunction

  // Advance the decoder by one accepted raw byte
  function void note_input(logic [7:0] c, logic last);
    logic [7:0] d;
    case (mode)
      ESC_IDLE: begin
        if (c == CH_BSL) begin
          if (last) push(8'h00, STATUS_BSL_END, 1'b1);
          else mode = ESC_OPEN;
        end else begin
          push(c, STATUS_OK, last);
        end
      end
      ESC_OPEN: begin
        if (c == CH_X || c == CH_U) begin
          accum   = 8'h00;
          stopped = 1'b0;
          if (last) push(8'h00, (c == CH_X) ? STATUS_OK : STATUS_UNI_TRC, 1'b1);
          else mode = (c == CH_X) ? ESC_X_HI : ESC_U_SKIP1;
        end else begin
          d = c;
          if (c == CH_B) d = CC_BS;
          else if (c == CH_F) d = CC_FF;
          else if (c == CH_N) d = CC_LF;
          else if (c == CH_R) d = CC_CR;
          else if (c == CH_T) d = CC_TAB;
          push(d, STATUS_OK, last);
          mode = ESC_IDLE;
        end
      end
      ESC_X_HI, ESC_U_HI: begin
        take_digit(c);
        if (last) push(accum, STATUS_OK, 1'b1);
        else mode = (mode == ESC_X_HI) ? ESC_X_LO : ESC_U_LO;
      end
      ESC_X_LO, ESC_U_LO: begin
        take_digit(c);
        push(accum, STATUS_OK, last);
        mode = ESC_IDLE;
      end
      ESC_U_SKIP1: begin
        if (last) push(8'h00, STATUS_UNI_TRC, 1'b1);
        else mode = ESC_U_SKIP2;
      end
      default: begin
        if (last) push(8'h00, STATUS_OK, 1'b1);
        else mode = ESC_U_HI;
      end
    endcase
    if (last) clear_state();
  endfunction

  // Compare one result transfer with the oldest prediction
  function void check_result(logic [7:0] data, status_t status, logic last);
    decoded_t d;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: out_byte %02h out_status %0d out_last %0d",
             data, status, last);
      errors++;
      return;
    end
    d = decoded_q.pop_front();
    if (data !== d.data) begin
      $error("out_byte: expected %02h, actual %02h", d.data, data);
      errors++;
    end
    if (status !== d.status) begin
      $error("out_status: expected %0d, actual %0d", d.status, status);
      errors++;
    end
    if (last !== d.last) begin
      $error("out_last: expected %0d, actual %0d", d.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return decoded_q.size();
  endfunction

  // Flag predictions that never arrived
  function void finish();
    if (decoded_q.size() != 0) begin
      $error("%0d expected results never arrived", decoded_q.size());
      errors++;
    end
  endfunction
endclass

module tb_json_string_unescape;

  localparam int         RANDOM_ITEMS = 850;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam string      HEX_CHARS    = "0123456789abcdefABCDEF";

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  status_t    out_status;
  logic       out_last;

  // Suppress idling on both sides while set
  logic       steady    = 1'b0;
  int         sent      = 0;
  logic [7:0] text_q[$];

  unescape_scoreboard sb;

  json_string_unescape uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stall the output at random and check each result transfer
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_byte, out_status, out_last);
      out_stall <= !steady && ($urandom_range(99) < 26);
    end
  end

  // Offer one raw byte after a random gap and hold it until the transfer
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 26 && gap < 16) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (in_stall);
    sb.note_input(b, last);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Send the queued bytes as one string, last flag on the final byte
  task automatic send_queue();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Mostly hex digits, sometimes any byte to stop the decode early
  function automatic logic [7:0] pick_digit();
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    return HEX_CHARS[$urandom_range(HEX_CHARS.len() - 1)];
  endfunction

  // Append one plain byte or one escape with random content
  task automatic add_token();
    logic [7:0] letters[8];
    letters = '{CH_B, CH_F, CH_N, CH_R, CH_T, CH_BSL, CH_QUOTE, CH_SLASH};
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        text_q.push_back(8'($urandom_range(255)));
      end
      4, 5: begin
        text_q.push_back(CH_BSL);
        if ($urandom_range(3) == 0) text_q.push_back(8'($urandom_range(255)));
        else text_q.push_back(letters[$urandom_range(7)]);
      end
      6, 7: begin
        text_q.push_back(CH_BSL);
        text_q.push_back(CH_X);
        repeat (2) text_q.push_back(pick_digit());
      end
      default: begin
        text_q.push_back(CH_BSL);
        text_q.push_back(CH_U);
        repeat (4) text_q.push_back(pick_digit());
      end
    endcase
  endtask

  // Hold the sender until every predicted result has arrived
  task automatic wait_drained();
    int guard;
    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    int cut;
    int base;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme bytes, hex stops, unicode low byte, strings that end mid-escape
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\\xFg\\xG5\\u12aB\\q");
    send_text("\\");
    send_text("\\u");
    send_text("\\u1");
    send_text("\\x");
    send_text("\\u12");
    send_text("\\x7");

    // Pause the sender until the directed results have drained
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    // Random strings: well-formed escapes, some cut short, some noise
    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      steady <= (sent - base >= 400) && (sent - base < 550);
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(12, 1)) begin
          if ($urandom_range(2) == 0) text_q.push_back(CH_BSL);
          else text_q.push_back(8'($urandom_range(255)));
        end
      end else begin
        repeat ($urandom_range(6, 1)) add_token();
        if ($urandom_range(99) < 20) begin
          cut = $urandom_range(text_q.size(), 1);
          while (text_q.size() > cut) void'(text_q.pop_back());
        end
      end
      send_queue();
    end
    in_valid <= 1'b0;
    steady   <= 1'b0;

    wait_drained();
    repeat (4) @(posedge clk);
    sb.finish();
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Stop a hung run
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
